// File: hdl/bfm3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfm3_pkg;

  // murmur3 x86_32 constants
  localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2     = 32'h1b873593;
  localparam logic [31:0] MIX_ADD    = 32'he6546b64;
  localparam logic [31:0] FMIX_C1    = 32'h85ebca6b;
  localparam logic [31:0] FMIX_C2    = 32'hc2b2ae35;
  localparam logic [31:0] SEED_STEP  = 32'hFBA4C795;

  localparam int HCNT_W = 6;
  localparam int FBYTES_W = 16;
  localparam int DIV_STEPS = 29;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_QUERY   = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_REFRESH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_TWEAK  = 2'd0,
    REG_HCOUNT = 2'd1,
    REG_FBYTES = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_H_INIT,
    S_H_FETCH,
    S_H_K1,
    S_H_K2,
    S_H_BLK,
    S_H_F0,
    S_H_F1,
    S_H_F2,
    S_H_F3,
    S_H_DIV,
    S_H_MRD,
    S_H_MUSE,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: hdl/bfm3_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bfm3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/bloom_filter_murmur3_top.sv
`timescale 1ns / 1ps
`default_nettype none
// bloom filter with murmur3 x86_32 index hashing over a byte-wide bit store
// in_*: key beats (tuser = action, tlast = last key word); an insert or query beat without
//   tlast only appends key bytes and gives no result beat
// out_*: one result beat per finished key, clear or refresh
// cfg_*: register writes (0 tweak, 1 hash count, 2 filter bytes), always ready
// after reset the whole store (STORE_BYTES bytes) is zeroed by a sweep; no input
//   beat is taken until it ends, config writes are taken throughout
// a finished key runs, per hash, a setup step, four steps per key block (fetch,
//   two mix multiplies, block update), four finalizer steps, a restoring
//   remainder unit for the byte index and a read-modify-write of the store
//   (registered read); a query stops at its first zero bit; the accept and
//   the load of the result register come on top
// clear writes one byte in use per cycle; refresh reads, then checks, each byte in use (store port)
// results wait in an output register; a new beat is accepted while it waits,
//   and the block holds its next result until the receiver takes the old one
module bloom_filter_murmur3_top #(
  parameter int STORE_BYTES = 32768,
  parameter int MAX_HASHES  = 50,
  parameter int KEY_BYTES   = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // key_word[31:0], word_bytes[34:32], zero pad
  input  wire logic [1:0]  in_tuser,   // action[1:0]
  input  wire logic        in_tlast,   // key_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // hit, filter_empty, filter_full, key_too_long, zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import bfm3_pkg::*;

  localparam int LANE_DEPTH = (KEY_BYTES + 3) / 4;
  localparam int LAW = LANE_DEPTH > 1 ? $clog2(LANE_DEPTH) : 1;
  localparam int BW  = $clog2(LANE_DEPTH + 1);
  localparam int LW  = $clog2(KEY_BYTES + 1);
  localparam int SAW = STORE_BYTES > 1 ? $clog2(STORE_BYTES) : 1;
  localparam int CW  = $clog2(STORE_BYTES + 1);

  // control and config registers
  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 empty_r, empty_nxt;
  logic                 full_r, full_nxt;
  logic [31:0]          tweak_r, tweak_nxt;
  logic [HCNT_W-1:0]    hcnt_r, hcnt_nxt;
  logic [FBYTES_W-1:0]  fbytes_r, fbytes_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // datapath registers
  logic                 ins_r, ins_nxt;
  logic [HCNT_W-1:0]    hidx_r, hidx_nxt;
  logic [31:0]          seed_r, seed_nxt;
  logic [31:0]          h_r, h_nxt;
  logic [31:0]          k_r, k_nxt;
  logic [BW-1:0]        blk_r, blk_nxt;
  logic [15:0]          rem_r, rem_nxt;
  logic [4:0]           dcnt_r, dcnt_nxt;
  logic [2:0]           bit_r, bit_nxt;
  logic [SAW-1:0]       st_addr_r, st_addr_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic                 res_tl_r, res_tl_nxt;
  logic [7:0]           out_data_r, out_data_nxt;

  // input beat fields
  action_t     in_action;
  logic [31:0] in_word;
  logic [2:0]  in_nb;
  logic [2:0]  nb_sat;
  logic        in_acc;

  assign in_action = action_t'(in_tuser);
  assign in_word   = in_tdata[31:0];
  assign in_nb     = in_tdata[34:32];
  assign nb_sat    = (in_nb > 3'd4) ? 3'd4 : in_nb;
  assign in_acc    = in_tvalid && in_tready;

  // effective configuration
  logic [FBYTES_W-1:0] ub;
  logic [HCNT_W-1:0]   uh;
  assign ub = (fbytes_r == '0) ? FBYTES_W'(1) :
              (fbytes_r > FBYTES_W'(STORE_BYTES)) ? FBYTES_W'(STORE_BYTES) : fbytes_r;
  assign uh = (hcnt_r > HCNT_W'(MAX_HASHES)) ? HCNT_W'(MAX_HASHES) : hcnt_r;

  // key block bookkeeping
  logic [BW-1:0] blocks;
  logic [BW-1:0] nblk;
  logic [1:0]    tail;
  assign tail   = len_r[1:0];
  assign blocks = BW'(len_r >> 2);
  assign nblk   = blocks + BW'(tail != 2'd0);

  // key buffer: four byte lanes, key byte j sits in lane j%4 at row j/4
  logic [3:0]     lane_we;
  logic [LAW-1:0] lane_waddr [4];
  logic [7:0]     lane_wdata [4];
  logic [7:0]     lane_rdata [4];
  logic [LAW-1:0] lane_raddr;
  assign lane_raddr = blk_r[LAW-1:0];

  genvar gl;
  generate
    for (gl = 0; gl < 4; gl++) begin : g_lane
      bfm3_ram #(.WIDTH(8), .DEPTH(LANE_DEPTH)) u_lane (
        .clk   (clk),
        .we    (lane_we[gl]),
        .waddr (lane_waddr[gl]),
        .wdata (lane_wdata[gl]),
        .raddr (lane_raddr),
        .rdata (lane_rdata[gl])
      );
    end
  endgenerate

  // bit store
  logic           st_we;
  logic [SAW-1:0] st_waddr;
  logic [7:0]     st_wdata;
  logic [SAW-1:0] st_raddr;
  logic [7:0]     st_rdata;

  bfm3_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // key word as read from the lanes, tail bytes masked
  logic [31:0] kword;
  logic [31:0] kmask;
  always_comb begin
    kword = {lane_rdata[3], lane_rdata[2], lane_rdata[1], lane_rdata[0]};
    kmask = 32'hffffffff;
    if (blk_r == blocks) begin
      case (tail)
        2'd1:    kmask = 32'h000000ff;
        2'd2:    kmask = 32'h0000ffff;
        2'd3:    kmask = 32'h00ffffff;
        default: kmask = 32'hffffffff;
      endcase
    end
  end

  // lane write steering for an appended key word
  logic          fits;
  logic [LW:0]   len_sum;
  always_comb begin
    len_sum = {1'b0, len_r} + (LW + 1)'(nb_sat);
    fits    = len_sum <= (LW + 1)'(KEY_BYTES);
  end

  always_comb begin
    logic [1:0]  off;
    logic [LW:0] pos;
    for (int j = 0; j < 4; j++) begin
      off           = 2'(j) - len_r[1:0];
      pos           = {1'b0, len_r} + (LW + 1)'(off);
      lane_we[j]    = in_acc && (in_action == ACT_INSERT || in_action == ACT_QUERY)
                      && fits && ({1'b0, off} < nb_sat);
      lane_waddr[j] = LAW'(pos >> 2);
      lane_wdata[j] = 8'(in_word >> {off, 3'b000});
    end
  end

  logic [CW-1:0] cnt_inc;
  logic          cnt_end;
  assign cnt_inc = cnt_r + CW'(1);
  assign cnt_end = 17'(cnt_inc) == 17'(ub);

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    logic [31:0] t;
    logic [16:0] dt;
    logic        ovf_now;

    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    empty_nxt    = empty_r;
    full_nxt     = full_r;
    tweak_nxt    = tweak_r;
    hcnt_nxt     = hcnt_r;
    fbytes_nxt   = fbytes_r;
    ins_nxt      = ins_r;
    hidx_nxt     = hidx_r;
    seed_nxt     = seed_r;
    h_nxt        = h_r;
    k_nxt        = k_r;
    blk_nxt      = blk_r;
    rem_nxt      = rem_r;
    dcnt_nxt     = dcnt_r;
    bit_nxt      = bit_r;
    st_addr_nxt  = st_addr_r;
    res_hit_nxt  = res_hit_r;
    res_tl_nxt   = res_tl_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    st_we    = 1'b0;
    st_waddr = cnt_r[SAW-1:0];
    st_wdata = 8'h00;
    st_raddr = st_addr_r;

    t       = '0;
    dt      = '0;
    ovf_now = 1'b0;

    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_TWEAK:  tweak_nxt  = cfg_data;
        REG_HCOUNT: hcnt_nxt   = cfg_data[HCNT_W-1:0];
        REG_FBYTES: fbytes_nxt = cfg_data[FBYTES_W-1:0];
        default:    ;
      endcase
    end

    case (state_r)
      S_INIT: begin
        st_we   = 1'b1;
        cnt_nxt = cnt_inc;
        if (cnt_inc == CW'(STORE_BYTES)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          res_hit_nxt = 1'b0;
          res_tl_nxt  = 1'b0;
          case (in_action)
            ACT_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_CLR;
            end
            ACT_REFRESH: begin
              cnt_nxt   = '0;
              empty_nxt = 1'b1;
              full_nxt  = 1'b1;
              state_nxt = S_SCAN_RD;
            end
            default: begin
              ovf_now = ovf_r || !fits;
              if (fits) begin
                len_nxt = len_sum[LW-1:0];
              end else begin
                ovf_nxt = 1'b1;
              end
              if (in_tlast) begin
                ins_nxt  = (in_action == ACT_INSERT);
                hidx_nxt = '0;
                seed_nxt = tweak_r;
                if (ovf_now) begin
                  res_tl_nxt = 1'b1;
                  len_nxt    = '0;
                  ovf_nxt    = 1'b0;
                  state_nxt  = S_DONE;
                end else if (in_action == ACT_INSERT) begin
                  if (full_r) begin
                    len_nxt   = '0;
                    state_nxt = S_DONE;
                  end else if (uh == '0) begin
                    empty_nxt = 1'b0;
                    len_nxt   = '0;
                    state_nxt = S_DONE;
                  end else begin
                    state_nxt = S_H_INIT;
                  end
                end else begin
                  if (full_r) begin
                    res_hit_nxt = 1'b1;
                    len_nxt     = '0;
                    state_nxt   = S_DONE;
                  end else if (empty_r) begin
                    len_nxt   = '0;
                    state_nxt = S_DONE;
                  end else begin
                    res_hit_nxt = 1'b1;
                    if (uh == '0) begin
                      len_nxt   = '0;
                      state_nxt = S_DONE;
                    end else begin
                      state_nxt = S_H_INIT;
                    end
                  end
                end
              end
            end
          endcase
        end
      end

      S_CLR: begin
        st_we   = 1'b1;
        cnt_nxt = cnt_inc;
        if (cnt_end) begin
          empty_nxt = 1'b1;
          full_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end

      S_SCAN_RD: begin
        st_raddr  = cnt_r[SAW-1:0];
        state_nxt = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        empty_nxt = empty_r && (st_rdata == 8'h00);
        full_nxt  = full_r && (st_rdata == 8'hff);
        cnt_nxt   = cnt_inc;
        state_nxt = cnt_end ? S_DONE : S_SCAN_RD;
      end

      S_H_INIT: begin
        h_nxt     = seed_r;
        blk_nxt   = '0;
        state_nxt = (nblk == '0) ? S_H_F0 : S_H_FETCH;
      end

      S_H_FETCH: begin
        state_nxt = S_H_K1;
      end

      S_H_K1: begin
        t         = (kword & kmask) * MIX_C1;
        k_nxt     = {t[16:0], t[31:17]};
        state_nxt = S_H_K2;
      end

      S_H_K2: begin
        k_nxt     = k_r * MIX_C2;
        state_nxt = S_H_BLK;
      end

      S_H_BLK: begin
        t = h_r ^ k_r;
        if (blk_r == blocks) begin
          h_nxt = t;
        end else begin
          t     = {t[18:0], t[31:19]};
          h_nxt = (t << 2) + t + MIX_ADD;
        end
        blk_nxt   = blk_r + BW'(1);
        state_nxt = (blk_nxt == nblk) ? S_H_F0 : S_H_FETCH;
      end

      S_H_F0: begin
        t         = h_r ^ 32'(len_r);
        h_nxt     = t ^ (t >> 16);
        state_nxt = S_H_F1;
      end

      S_H_F1: begin
        h_nxt     = h_r * FMIX_C1;
        state_nxt = S_H_F2;
      end

      S_H_F2: begin
        t         = h_r ^ (h_r >> 13);
        h_nxt     = t * FMIX_C2;
        state_nxt = S_H_F3;
      end

      S_H_F3: begin
        // byte index = (h >> 3) mod bytes in use, bit = h & 7
        t         = h_r ^ (h_r >> 16);
        bit_nxt   = t[2:0];
        h_nxt     = {t[31:3], 3'b000};
        rem_nxt   = '0;
        dcnt_nxt  = 5'(DIV_STEPS - 1);
        state_nxt = S_H_DIV;
      end

      S_H_DIV: begin
        dt = {rem_r, h_r[31]};
        if (dt >= {1'b0, ub}) begin
          dt = dt - {1'b0, ub};
        end
        rem_nxt  = dt[15:0];
        h_nxt    = h_r << 1;
        dcnt_nxt = dcnt_r - 5'd1;
        if (dcnt_r == 5'd0) begin
          st_addr_nxt = dt[SAW-1:0];
          state_nxt   = S_H_MRD;
        end
      end

      S_H_MRD: begin
        state_nxt = S_H_MUSE;
      end

      S_H_MUSE: begin
        if (ins_r) begin
          st_we    = 1'b1;
          st_waddr = st_addr_r;
          st_wdata = st_rdata | (8'h01 << bit_r);
        end
        if ((!ins_r && !st_rdata[bit_r]) || (hidx_r + HCNT_W'(1) == uh)) begin
          if (!ins_r && !st_rdata[bit_r]) begin
            res_hit_nxt = 1'b0;
          end
          if (ins_r) begin
            empty_nxt = 1'b0;
          end
          len_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          hidx_nxt  = hidx_r + HCNT_W'(1);
          seed_nxt  = seed_r + SEED_STEP;
          state_nxt = S_H_INIT;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000, res_tl_r, full_r, empty_r, res_hit_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      empty_r     <= 1'b1;
      full_r      <= 1'b0;
      tweak_r     <= '0;
      hcnt_r      <= HCNT_W'(1);
      fbytes_r    <= FBYTES_W'(32768);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      empty_r     <= empty_nxt;
      full_r      <= full_nxt;
      tweak_r     <= tweak_nxt;
      hcnt_r      <= hcnt_nxt;
      fbytes_r    <= fbytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r      <= ins_nxt;
    hidx_r     <= hidx_nxt;
    seed_r     <= seed_nxt;
    h_r        <= h_nxt;
    k_r        <= k_nxt;
    blk_r      <= blk_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    bit_r      <= bit_nxt;
    st_addr_r  <= st_addr_nxt;
    res_hit_r  <= res_hit_nxt;
    res_tl_r   <= res_tl_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_bloom_filter_murmur3_top.sv
`timescale 1ns / 1ps
module tb_bloom_filter_murmur3_top;
  import bfm3_pkg::*;

  localparam int STORE_BYTES = 32768;
  localparam int MAX_HASHES  = 50;
  localparam int KEY_BYTES   = 64;
  localparam int TOTAL_BEATS = 1050;

  // result bit positions in out_tdata
  localparam int R_HIT   = 0;
  localparam int R_EMPTY = 1;
  localparam int R_FULL  = 2;
  localparam int R_LONG  = 3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // key_word[31:0], word_bytes[34:32], zero pad
  logic [1:0]  in_tuser;    // action[1:0]
  logic        in_tlast;    // key_last
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // hit, filter_empty, filter_full, key_too_long, zero pad
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  bloom_filter_murmur3_top #(
    .STORE_BYTES(STORE_BYTES),
    .MAX_HASHES (MAX_HASHES),
    .KEY_BYTES  (KEY_BYTES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------
  // shadow of the filter: bit store, key buffer, flags and registers
  // ---------------------------------------------------------------------
  bit [7:0]  store_img [STORE_BYTES];
  bit [7:0]  key_img [KEY_BYTES];
  int        key_len;
  bit        key_ovf;
  bit        flag_empty;
  bit        flag_full;
  bit [31:0] tweak_reg;
  bit [5:0]  hcount_reg;
  bit [15:0] fbytes_reg;

  // expected result beats, oldest first
  bit [3:0]  flag_q [$];

  int        mismatches;
  int        beats_sent;

  // idling controls
  bit        no_idle;
  int        hold_cycles;   // long receiver hold-off
  int        rx_stall;      // per-result receiver stall

  function automatic bit [31:0] rotl(bit [31:0] v, int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic bit [31:0] scramble(bit [31:0] k);
    k = k * 32'hcc9e2d51;
    k = rotl(k, 15);
    return k * 32'h1b873593;
  endfunction

  // murmur3 x86_32 over the buffered key bytes
  function automatic bit [31:0] murmur_key(bit [31:0] seed);
    bit [31:0] h;
    bit [31:0] k;
    int nblk;
    int b;
    h = seed;
    nblk = key_len / 4;
    for (b = 0; b < nblk; b++) begin
      k = {key_img[4*b+3], key_img[4*b+2], key_img[4*b+1], key_img[4*b]};
      h ^= scramble(k);
      h = rotl(h, 13);
      h = h * 5 + 32'he6546b64;
    end
    k = '0;
    if ((key_len & 3) == 3) k ^= {8'h0, key_img[4*nblk+2], 16'h0};
    if ((key_len & 3) >= 2) k ^= {16'h0, key_img[4*nblk+1], 8'h0};
    if ((key_len & 3) >= 1) begin
      k ^= {24'h0, key_img[4*nblk]};
      h ^= scramble(k);
    end
    h ^= key_len;
    h ^= h >> 16;
    h = h * 32'h85ebca6b;
    h ^= h >> 13;
    h = h * 32'hc2b2ae35;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic int bytes_in_use();
    if (fbytes_reg == 0) return 1;
    if (fbytes_reg > STORE_BYTES) return STORE_BYTES;
    return fbytes_reg;
  endfunction

  function automatic int hashes_in_use();
    return (hcount_reg > MAX_HASHES) ? MAX_HASHES : hcount_reg;
  endfunction

  function automatic bit [31:0] store_bit(int i);
    bit [31:0] seed;
    seed = i * SEED_STEP + tweak_reg;
    return murmur_key(seed) % (bytes_in_use() * 8);
  endfunction

  // advance the shadow by one accepted beat, queue a result if one is due
  task automatic predict_beat(action_t act, bit [31:0] word, bit [2:0] nb, bit last);
    int i;
    int n;
    bit [31:0] idx;
    bit hit;
    bit long_key;
    bit all_ff;
    bit all_00;
    hit = 0;
    long_key = 0;
    if (act == ACT_CLEAR) begin
      for (i = 0; i < bytes_in_use(); i++) store_img[i] = 8'h00;
      flag_full = 0;
      flag_empty = 1;
    end else if (act == ACT_REFRESH) begin
      all_ff = 1;
      all_00 = 1;
      for (i = 0; i < bytes_in_use(); i++) begin
        if (store_img[i] != 8'hff) all_ff = 0;
        if (store_img[i] != 8'h00) all_00 = 0;
      end
      flag_full = all_ff;
      flag_empty = all_00;
    end else begin
      n = (nb > 4) ? 4 : nb;
      if (key_len + n > KEY_BYTES) key_ovf = 1;
      else begin
        for (i = 0; i < n; i++) key_img[key_len + i] = word[8*i +: 8];
        key_len += n;
      end
      if (!last) return;
      if (key_ovf) long_key = 1;
      else if (act == ACT_INSERT) begin
        if (!flag_full) begin
          for (i = 0; i < hashes_in_use(); i++) begin
            idx = store_bit(i);
            store_img[idx >> 3][idx[2:0]] = 1'b1;
          end
          flag_empty = 0;
        end
      end else if (flag_full) hit = 1;
      else if (!flag_empty) begin
        hit = 1;
        for (i = 0; i < hashes_in_use() && hit; i++) begin
          idx = store_bit(i);
          if (!store_img[idx >> 3][idx[2:0]]) hit = 0;
        end
      end
      key_len = 0;
      key_ovf = 0;
    end
    flag_q.push_back({long_key, flag_full, flag_empty, hit});
  endtask

  // ---------------------------------------------------------------------
  // sender: one beat on the input stream
  // ---------------------------------------------------------------------
  task automatic send_beat(action_t act, bit [31:0] word, bit [2:0] nb, bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, nb, word};
    in_tuser  <= act;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_beat(act, word, nb, last);
    beats_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // sender pauses until every expected result is back
  task automatic drain();
    release_input();
    while (flag_q.size() != 0) @(posedge clk);
    // a trailing non-last word may still be in flight
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TWEAK:  tweak_reg  = val;
      REG_HCOUNT: hcount_reg = val[5:0];
      default:    fbytes_reg = val[15:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(bit [31:0] tw, bit [31:0] hc, bit [31:0] fb);
    drain();
    write_reg(REG_TWEAK, tw);
    write_reg(REG_HCOUNT, hc);
    write_reg(REG_FBYTES, fb);
  endtask

  // ---------------------------------------------------------------------
  // key pool: reused keys give query hits
  // ---------------------------------------------------------------------
  bit [31:0] pool_word [8][17];
  int        pool_len [8];
  bit [2:0]  pool_tail [8];

  task automatic make_key(int id);
    int w;
    pool_len[id] = ($urandom_range(0, 19) == 0) ? 17 : $urandom_range(1, 5);
    for (w = 0; w < 17; w++) begin
      case ($urandom_range(0, 7))
        0:       pool_word[id][w] = 32'h0;
        1:       pool_word[id][w] = 32'hffffffff;
        default: pool_word[id][w] = $urandom;
      endcase
    end
    pool_tail[id] = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(1, 4));
  endtask

  // earlier words carry random insert/query, the last word decides
  task automatic send_key(int id, action_t last_act);
    int w;
    action_t a;
    for (w = 0; w < pool_len[id]; w++) begin
      a = $urandom_range(0, 1) ? ACT_QUERY : ACT_INSERT;
      if (w == pool_len[id] - 1)
        send_beat(last_act, pool_word[id][w], pool_tail[id], 1'b1);
      else
        send_beat(a, pool_word[id][w], 3'd4, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------
  // receiver: ready with random stalls and an optional long hold-off
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    bit [3:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      rx_stall <= no_idle ? 0 : $urandom_range(0, 15);
      if (flag_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %b", out_tdata[3:0]);
      end else begin
        want = flag_q.pop_front();
        if (out_tdata[R_HIT] !== want[R_HIT] || out_tdata[R_EMPTY] !== want[R_EMPTY] ||
            out_tdata[R_FULL] !== want[R_FULL] || out_tdata[R_LONG] !== want[R_LONG]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: hit/empty/full/too_long exp %b %b %b %b got %b %b %b %b",
                     want[R_HIT], want[R_EMPTY], want[R_FULL], want[R_LONG],
                     out_tdata[R_HIT], out_tdata[R_EMPTY], out_tdata[R_FULL],
                     out_tdata[R_LONG]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // field extremes, every action, odd byte counts, mixed actions, zero hashes
  task automatic test_directed();
    configure(32'h0, 4, 16);
    send_beat(ACT_QUERY, 32'h0, 3'd4, 1'b1);          // query of empty filter
    send_beat(ACT_INSERT, 32'hffffffff, 3'd4, 1'b0);
    send_beat(ACT_INSERT, 32'h0, 3'd1, 1'b1);
    send_beat(ACT_QUERY, 32'hffffffff, 3'd4, 1'b0);
    send_beat(ACT_QUERY, 32'h0, 3'd1, 1'b1);          // same key, should hit
    send_beat(ACT_QUERY, 32'h12345678, 3'd3, 1'b1);
    send_beat(ACT_INSERT, 32'hdeadbeef, 3'd0, 1'b0);  // zero bytes appends nothing
    send_beat(ACT_QUERY, 32'hcafef00d, 3'd7, 1'b0);   // 5..7 count as four
    send_beat(ACT_INSERT, 32'h5a5a5a5a, 3'd5, 1'b1);  // mixed actions, insert wins
    send_beat(ACT_INSERT, 32'ha5a5a5a5, 3'd6, 1'b0);
    send_beat(ACT_CLEAR, 32'hffffffff, 3'd7, 1'b1);   // clear keeps partial key
    send_beat(ACT_REFRESH, 32'h0, 3'd0, 1'b0);
    send_beat(ACT_QUERY, 32'h0, 3'd2, 1'b1);
    configure(32'hffffffff, 0, 8);
    send_beat(ACT_QUERY, 32'h1, 3'd4, 1'b1);
    send_beat(ACT_INSERT, 32'h2, 3'd4, 1'b1);         // zero hashes: not empty now
    send_beat(ACT_QUERY, 32'h3, 3'd4, 1'b1);          // neither flag: hits
    send_beat(ACT_REFRESH, 32'h0, 3'd4, 1'b1);
  endtask

  // key longer than the buffer
  task automatic test_key_overflow();
    int w;
    configure(32'h13579bdf, 63, 3);
    for (w = 0; w < 17; w++) send_beat(ACT_INSERT, $urandom, 3'd4, w == 16);
    for (w = 0; w < 16; w++) send_beat(ACT_QUERY, $urandom, 3'd4, 1'b0);
    send_beat(ACT_QUERY, $urandom, 3'd0, 1'b1);       // exactly the buffer size
  endtask

  // tiny filter filled up: full matches all and skips inserts
  task automatic test_full_filter();
    int n;
    configure($urandom, 50, 0);
    send_beat(ACT_CLEAR, 32'h0, 3'd4, 1'b1);
    for (n = 0; n < 6; n++) send_beat(ACT_INSERT, $urandom, 3'd4, 1'b1);
    send_beat(ACT_REFRESH, 32'h0, 3'd4, 1'b1);
    send_beat(ACT_QUERY, $urandom, 3'd4, 1'b1);
    send_beat(ACT_INSERT, $urandom, 3'd2, 1'b1);
    send_beat(ACT_CLEAR, 32'h0, 3'd4, 1'b1);
  endtask

  // whole store in use, with the size register at its top
  task automatic test_large_store();
    configure(32'h0, 2, 16'hffff);
    send_beat(ACT_INSERT, $urandom, 3'd4, 1'b1);
    send_beat(ACT_REFRESH, 32'h0, 3'd4, 1'b1);
    send_beat(ACT_CLEAR, 32'h0, 3'd4, 1'b1);
  endtask

  // receiver holds off while keys keep coming, input must stall
  task automatic test_backpressure();
    int n;
    configure($urandom, 1, 4);
    no_idle = 1;
    hold_cycles = 600;
    for (n = 0; n < 12; n++) send_beat(ACT_INSERT, $urandom, 3'd4, 1'b1);
    no_idle = 0;
    drain();
  endtask

  task automatic test_random();
    int id;
    int pick;
    int since_cfg;
    for (id = 0; id < 8; id++) make_key(id);
    since_cfg = 1000;
    while (beats_sent < TOTAL_BEATS) begin
      if (since_cfg > 80) begin
        // mostly small stores and few hashes keep the run short
        configure($urandom,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(50, 63) : $urandom_range(0, 8),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 512) : $urandom_range(1, 64));
        no_idle = ($urandom_range(0, 3) == 0);
        since_cfg = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_beat(ACT_CLEAR, $urandom, 3'($urandom), 1'($urandom));
        since_cfg++;
      end else if (pick < 14) begin
        send_beat(ACT_REFRESH, $urandom, 3'($urandom), 1'($urandom));
        since_cfg++;
      end else begin
        id = $urandom_range(0, 7);
        if ($urandom_range(0, 9) < 3) make_key(id);
        send_key(id, $urandom_range(0, 1) ? ACT_QUERY : ACT_INSERT);
        since_cfg += pool_len[id];
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_cycles = 0;
    rx_stall = 0;
    no_idle = 0;
    mismatches = 0;
    beats_sent = 0;
    key_len = 0;
    key_ovf = 0;
    flag_empty = 1;
    flag_full = 0;
    tweak_reg = 32'h0;
    hcount_reg = 6'd1;
    fbytes_reg = 16'd32768;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_key_overflow();
    test_full_filter();
    test_backpressure();
    test_large_store();
    test_random();

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && flag_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
hdl/bfm3_pkg.sv
hdl/bfm3_ram.sv
hdl/bloom_filter_murmur3_top.sv
tb/sv/tb_bloom_filter_murmur3_top.sv
